// ----- design/ecmp_pkg.sv -----
package ecmp_pkg;

	// field widths
	localparam int IDX_W    = 4;
	localparam int TIME_W   = 32;
	localparam int SPAN_W   = 16;
	localparam int CELL_W   = 8;
	localparam int OFFS_W   = 10;
	localparam int X_W      = 13;
	localparam int Y_W      = 12;

	// Q0.16 fraction, divider resolves DIV_STEPS quotient bits per stage
	localparam int Q_W        = 16;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = Q_W / DIV_STEPS;

	// smoothstep: 3 in Q.16, and 1.0 for the arrived case
	localparam int              T_W        = Q_W + 2;
	localparam logic [T_W-1:0]  EASE_THREE = T_W'(3 * (1 << Q_W));
	localparam logic [Q_W:0]    S_ONE      = (Q_W + 1)'(1 << Q_W);

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_PIXELS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_OFFSET = CFG_IDX_W'(1);

	typedef struct packed {
		logic [IDX_W-1:0]  from_row;
		logic [IDX_W-1:0]  from_col;
		logic [IDX_W-1:0]  to_row;
		logic [IDX_W-1:0]  to_col;
		logic [TIME_W-1:0] begin_time;
		logic [SPAN_W-1:0] span;
		logic [TIME_W-1:0] now_time;
	} item_t;

	typedef struct packed {
		logic [X_W-1:0] pos_x;
		logic [Y_W-1:0] pos_y;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] write_data;
	} cfg_write_t;

	// per-axis start point, distance to travel and direction
	typedef struct packed {
		logic [X_W-1:0] from_x;
		logic [X_W-1:0] dist_x;
		logic           neg_x;
		logic [Y_W-1:0] from_y;
		logic [Y_W-1:0] dist_y;
		logic           neg_y;
		logic           dest;
	} geom_t;

	// divider pipeline word
	typedef struct packed {
		logic [Q_W-1:0]    rem;
		logic [Q_W-1:0]    quo;
		logic [SPAN_W-1:0] span;
		geom_t             geom;
	} div_t;

endpackage

// ----- design/ecmp_chan_if.sv -----
interface ecmp_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- design/ecmp_front.sv -----
// Two front stages: cell centres and time window, then per-axis distance.
module ecmp_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  ecmp_pkg::item_t                item,
	input  logic [ecmp_pkg::CELL_W-1:0]    cell_pixels,
	input  logic [ecmp_pkg::OFFS_W-1:0]    panel_offset,
	output logic                           out_valid,
	output ecmp_pkg::div_t                 out
);

	typedef struct packed {
		logic [ecmp_pkg::X_W-1:0]    sx;
		logic [ecmp_pkg::X_W-1:0]    dx;
		logic [ecmp_pkg::Y_W-1:0]    sy;
		logic [ecmp_pkg::Y_W-1:0]    dy;
		logic                        dest;
		logic [ecmp_pkg::Q_W-1:0]    el;
		logic [ecmp_pkg::SPAN_W-1:0] span;
	} front_t;

	localparam int PROD_W = ecmp_pkg::IDX_W + ecmp_pkg::CELL_W;

	logic [PROD_W-1:0]             prod_fc, prod_tc, prod_fr, prod_tr;
	logic [ecmp_pkg::CELL_W-1:0]   half_cell;
	logic [ecmp_pkg::TIME_W:0]     end_time;
	logic [ecmp_pkg::TIME_W-1:0]   diff;
	logic                          started;
	logic                          arrived;
	front_t                        f1_d;
	front_t                        f1_s1;
	logic                          v_s1;
	ecmp_pkg::div_t                f2_d;
	ecmp_pkg::div_t                f2_s2;
	logic                          v_s2;

	// stage 1: centres and time window
	always_comb begin
		prod_fc   = PROD_W'(item.from_col) * PROD_W'(cell_pixels);
		prod_tc   = PROD_W'(item.to_col) * PROD_W'(cell_pixels);
		prod_fr   = PROD_W'(item.from_row) * PROD_W'(cell_pixels);
		prod_tr   = PROD_W'(item.to_row) * PROD_W'(cell_pixels);
		half_cell = cell_pixels >> 1;
		end_time  = {1'b0, item.begin_time} + (ecmp_pkg::TIME_W + 1)'(item.span);
		diff      = item.now_time - item.begin_time;
		started   = item.now_time > item.begin_time;
		arrived   = (item.span == '0) || ({1'b0, item.now_time} >= end_time);

		f1_d.sx   = ecmp_pkg::X_W'(prod_fc) + ecmp_pkg::X_W'(half_cell)
			+ ecmp_pkg::X_W'(panel_offset);
		f1_d.dx   = ecmp_pkg::X_W'(prod_tc) + ecmp_pkg::X_W'(half_cell)
			+ ecmp_pkg::X_W'(panel_offset);
		f1_d.sy   = ecmp_pkg::Y_W'(prod_fr) + ecmp_pkg::Y_W'(half_cell);
		f1_d.dy   = ecmp_pkg::Y_W'(prod_tr) + ecmp_pkg::Y_W'(half_cell);
		f1_d.dest = arrived;
		// inside the window the elapsed time is below span, so 16 bits hold it
		f1_d.el   = started ? diff[ecmp_pkg::Q_W-1:0] : '0;
		f1_d.span = item.span;
	end

	// stage 2: per-axis distance and direction, divider seed
	always_comb begin
		f2_d.rem         = f1_s1.el;
		f2_d.quo         = '0;
		f2_d.span        = f1_s1.span;
		f2_d.geom.from_x = f1_s1.sx;
		f2_d.geom.neg_x  = f1_s1.dx < f1_s1.sx;
		f2_d.geom.dist_x = f2_d.geom.neg_x ? (f1_s1.sx - f1_s1.dx) : (f1_s1.dx - f1_s1.sx);
		f2_d.geom.from_y = f1_s1.sy;
		f2_d.geom.neg_y  = f1_s1.dy < f1_s1.sy;
		f2_d.geom.dist_y = f2_d.geom.neg_y ? (f1_s1.sy - f1_s1.dy) : (f1_s1.dy - f1_s1.sy);
		f2_d.geom.dest   = f1_s1.dest;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s1 <= f1_d;
			f2_s2 <= f2_d;
		end
	end

	assign out_valid = v_s2;
	assign out       = f2_s2;

endmodule

// ----- design/ecmp_div_stage.sv -----
// One restoring-divider stage: DIV_STEPS quotient bits of el*2^16/span.
module ecmp_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  ecmp_pkg::div_t  in,
	output logic            out_valid,
	output ecmp_pkg::div_t  out
);

	logic [ecmp_pkg::Q_W-1:0] r;
	logic [ecmp_pkg::Q_W-1:0] q;
	logic [ecmp_pkg::Q_W:0]   r2;
	ecmp_pkg::div_t           d;
	ecmp_pkg::div_t           d_s1;
	logic                     v_s1;

	always_comb begin
		r  = in.rem;
		q  = in.quo;
		r2 = '0;
		for (int i = 0; i < ecmp_pkg::DIV_STEPS; i++) begin
			r2 = {r, 1'b0};
			if (r2 >= {1'b0, in.span}) begin
				r2 = r2 - {1'b0, in.span};
				q  = {q[ecmp_pkg::Q_W-2:0], 1'b1};
			end else begin
				q  = {q[ecmp_pkg::Q_W-2:0], 1'b0};
			end
			r = r2[ecmp_pkg::Q_W-1:0];
		end
		d      = in;
		d.rem  = r;
		d.quo  = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d;
		end
	end

	assign out_valid = v_s1;
	assign out       = d_s1;

endmodule

// ----- design/ecmp_ease.sv -----
// Smoothstep of the fraction and blend of both axes, three register stages.
module ecmp_ease (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  ecmp_pkg::div_t     in,
	output logic               out_valid,
	output ecmp_pkg::result_t  out
);

	localparam int PP_W = 2 * ecmp_pkg::Q_W;
	localparam int M_W  = PP_W + ecmp_pkg::T_W;
	localparam int S_W  = ecmp_pkg::Q_W + 1;
	localparam int MX_W = ecmp_pkg::X_W + S_W;
	localparam int MY_W = ecmp_pkg::Y_W + S_W;

	typedef struct packed {
		logic [PP_W-1:0]          pp;
		logic [ecmp_pkg::T_W-1:0] t;
		ecmp_pkg::geom_t          geom;
	} sq_t;

	typedef struct packed {
		logic [S_W-1:0]  s;
		ecmp_pkg::geom_t geom;
	} ss_t;

	typedef struct packed {
		logic [ecmp_pkg::X_W-1:0] mag_x;
		logic [ecmp_pkg::Y_W-1:0] mag_y;
		ecmp_pkg::geom_t          geom;
	} mag_t;

	sq_t                e1_d, e1_s1;
	ss_t                e2_d, e2_s2;
	mag_t               e3_d, e3_s3;
	logic               v_s1, v_s2, v_s3;
	logic [M_W-1:0]     m;
	logic [MX_W-1:0]    mx;
	logic [MY_W-1:0]    my;

	// p*p and 3-2p
	always_comb begin
		e1_d.pp   = PP_W'(in.quo) * PP_W'(in.quo);
		e1_d.t    = ecmp_pkg::EASE_THREE - ecmp_pkg::T_W'({in.quo, 1'b0});
		e1_d.geom = in.geom;
	end

	// s = p*p*(3-2p) >> 32; arrived items take s = 1.0
	always_comb begin
		m         = M_W'(e1_s1.pp) * M_W'(e1_s1.t);
		e2_d.s    = e1_s1.geom.dest ? ecmp_pkg::S_ONE
			: {1'b0, m[PP_W+ecmp_pkg::Q_W-1:PP_W]};
		e2_d.geom = e1_s1.geom;
	end

	// scaled distance, truncated
	always_comb begin
		mx         = MX_W'(e2_s2.geom.dist_x) * MX_W'(e2_s2.s);
		my         = MY_W'(e2_s2.geom.dist_y) * MY_W'(e2_s2.s);
		e3_d.mag_x = mx[ecmp_pkg::Q_W+ecmp_pkg::X_W-1:ecmp_pkg::Q_W];
		e3_d.mag_y = my[ecmp_pkg::Q_W+ecmp_pkg::Y_W-1:ecmp_pkg::Q_W];
		e3_d.geom  = e2_s2.geom;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1 <= e1_d;
			e2_s2 <= e2_d;
			e3_s3 <= e3_d;
		end
	end

	// final add/subtract goes straight into the output register
	always_comb begin
		out.pos_x = e3_s3.geom.neg_x ? (e3_s3.geom.from_x - e3_s3.mag_x)
			: (e3_s3.geom.from_x + e3_s3.mag_x);
		out.pos_y = e3_s3.geom.neg_y ? (e3_s3.geom.from_y - e3_s3.mag_y)
			: (e3_s3.geom.from_y + e3_s3.mag_y);
	end

	assign out_valid = v_s3;

endmodule

// ----- design/ecmp_out_buf.sv -----
// Output register plus one skid entry; full stalls the pipeline.
module ecmp_out_buf #(
	parameter type payload_t = logic
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  payload_t     push_data,
	output logic         full,
	ecmp_chan_if.source  egress
);

	payload_t out_q;
	payload_t skid_q;
	logic     out_v_q;
	logic     skid_v_q;
	logic     pop;
	logic     load_out;

	assign pop      = out_v_q && egress.ready;
	assign load_out = !out_v_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (load_out) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (load_out) begin
			out_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full         = skid_v_q;
	assign egress.valid = out_v_q;
	assign egress.data  = out_q;

endmodule

// ----- design/eased_cell_motion_position.sv -----
// Eased cell-to-cell motion position.
// ingress (sink): one beat per move - source and destination cell, start time,
//   duration and current time. egress (source): one beat per ingress beat with
//   the smoothstep-eased pixel centre (pos_x, pos_y), in ingress order.
// cfg (sink): register writes, always ready; index 0 cell_pixels,
//   index 1 panel_offset, other indices ignored. Write only while idle.
// Throughput: one beat per cycle while egress does not stall. Path: a beat
//   accepted on ingress passes through two front stages, eight divider stages
//   resolving two quotient bits each, three smoothstep/blend stages, then the
//   output register, from which it is shown on egress.
// Stall: egress has an output register and one skid entry. ingress.ready is
//   low only while the skid entry is occupied; the whole pipeline then holds,
//   nothing is dropped or repeated.
// Reset (arst_n low, asynchronous): all valid bits clear, cell_pixels goes to
//   64 and panel_offset to 0; ingress is ready once reset is released.
module eased_cell_motion_position (
	input  logic        clk,
	input  logic        arst_n,
	ecmp_chan_if.sink   ingress,
	ecmp_chan_if.source egress,
	ecmp_chan_if.sink   cfg
);

	localparam int NDIV = ecmp_pkg::DIV_STAGES;

	logic [ecmp_pkg::CELL_W-1:0] cell_pixels_q;
	logic [ecmp_pkg::OFFS_W-1:0] panel_offset_q;

	logic                        en;
	logic                        full;
	logic                        div_v [NDIV+1];
	ecmp_pkg::div_t              div_s [NDIV+1];
	logic                        res_valid;
	ecmp_pkg::result_t           res;

	// configuration registers; cfg never back-pressures
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_pixels_q  <= ecmp_pkg::CELL_W'(64);
			panel_offset_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.reg_index)
				ecmp_pkg::REG_CELL_PIXELS: begin
					cell_pixels_q <= cfg.data.write_data[ecmp_pkg::CELL_W-1:0];
				end
				ecmp_pkg::REG_PANEL_OFFSET: begin
					panel_offset_q <= cfg.data.write_data[ecmp_pkg::OFFS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// global advance: every stage moves unless the skid entry is taken
	assign en            = !full;
	assign ingress.ready = en;

	ecmp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (ingress.valid),
		.item         (ingress.data),
		.cell_pixels  (cell_pixels_q),
		.panel_offset (panel_offset_q),
		.out_valid    (div_v[0]),
		.out          (div_s[0])
	);

	// elapsed*2^16/span, two bits per stage
	for (genvar g = 0; g < NDIV; g++) begin : g_div
		ecmp_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (div_v[g]),
			.in        (div_s[g]),
			.out_valid (div_v[g+1]),
			.out       (div_s[g+1])
		);
	end

	ecmp_ease u_ease (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_v[NDIV]),
		.in        (div_s[NDIV]),
		.out_valid (res_valid),
		.out       (res)
	);

	ecmp_out_buf #(
		.payload_t (ecmp_pkg::result_t)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && res_valid),
		.push_data (res),
		.full      (full),
		.egress    (egress)
	);

	// skid entry is only ever used behind a waiting output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> egress.valid)
		else $error("skid entry occupied with empty output register");

	// a stalled receiver keeps the skid entry (and so the pipeline) held
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !egress.ready) |=> full)
		else $error("skid entry released without a beat taken");

	// divider remainder stays below the divisor for items still in motion
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(div_v[NDIV] && !div_s[NDIV].geom.dest) |-> (div_s[NDIV].rem < div_s[NDIV].span))
		else $error("divider remainder not below span");

endmodule
